// ----- rtl/core/cascaded_attitude_rate_pid_unit_assert.svh -----
// Assertion helpers, clocked on clk and held off during rst.
`ifndef CASCADED_ATTITUDE_RATE_PID_UNIT_ASSERT_SVH
`define CASCADED_ATTITUDE_RATE_PID_UNIT_ASSERT_SVH

// same-cycle implication
`define CPID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cpid_pkg.sv -----
`default_nettype none
package cpid_pkg;
  localparam int Axes   = 3;
  localparam int AngW   = 16;
  localparam int RateW  = 16;
  localparam int DtW    = 16;
  localparam int ErrW   = 17;
  localparam int GainW  = 16;
  localparam int IntW   = 24;
  localparam int LimW   = 23;
  localparam int MomW   = 32;
  localparam int AddrW  = 2;
  localparam int DivW   = ErrW + DtW;         // |diff| << 16
  localparam int InW    = 9 * AngW + DtW;     // 160
  localparam int OutW   = Axes * MomW;        // 96

  localparam logic signed [ErrW-1:0] AngPi    = 17'sd25736;
  localparam logic signed [ErrW-1:0] AngTwoPi = 17'sd51472;
  localparam logic [LimW-1:0]        LimitReset = 23'd655360;

  localparam logic [AddrW-1:0] RegProp  = 2'd0;
  localparam logic [AddrW-1:0] RegInteg = 2'd1;
  localparam logic [AddrW-1:0] RegDeriv = 2'd2;
  localparam logic [AddrW-1:0] RegLimit = 2'd3;

  typedef struct packed {
    logic load;    // capture word, form rate errors
    logic prep;    // load dividers
    logic step;    // one divider bit
    logic fin;     // sign and saturate derivative
    logic mult;    // derivative gain product
    logic commit;  // sum, update state, emit word
    logic zero;    // emit zero word (and clear if flagged)
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_skip;
    logic out_full;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/cpid_div.sv -----
`default_nettype none
// Restoring unsigned divider, one quotient bit per step.
module cpid_div (
  input  wire logic                      clk,
  input  wire logic                      start,
  input  wire logic                      step,
  input  wire logic [cpid_pkg::DivW-1:0] dividend,
  input  wire logic [cpid_pkg::DtW-1:0]  divisor,
  output logic      [cpid_pkg::DivW-1:0] quo
);
  import cpid_pkg::*;

  logic [DtW-1:0] rem;
  logic [DtW:0]   sh;
  logic [DtW:0]   sub;
  logic           ge;

  assign sh  = {rem, quo[DivW-1]};
  assign ge  = sh >= {1'b0, divisor};
  assign sub = sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (step) begin
      rem <= ge ? sub[DtW-1:0] : sh[DtW-1:0];
      quo <= {quo[DivW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/cpid_ctrl.sv -----
`default_nettype none
module cpid_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire cpid_pkg::stat_t st,
  output cpid_pkg::cmd_t       cmd
);
  import cpid_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StMult = 3'd4;
  localparam logic [2:0] StSum  = 3'd5;
  localparam logic [2:0] StZero = 3'd6;
  localparam int CntW = $clog2(DivW);

  logic [2:0]      state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  assign s_tready = (state == StIdle);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      StIdle: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = (st.in_clear || st.in_skip) ? StZero : StPrep;
        end
      end
      StPrep: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = StDiv;
      end
      StDiv: begin
        cmd.step = 1'b1;
        if (cnt == CntW'(DivW - 1)) state_next = StFin;
        else cnt_next = cnt + 1'b1;
      end
      StFin: begin
        cmd.fin    = 1'b1;
        state_next = StMult;
      end
      StMult: begin
        cmd.mult   = 1'b1;
        state_next = StSum;
      end
      StSum: begin
        if (!st.out_full) begin
          cmd.commit = 1'b1;
          state_next = StIdle;
        end
      end
      StZero: begin
        if (!st.out_full) begin
          cmd.zero   = 1'b1;
          state_next = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`include "cascaded_attitude_rate_pid_unit_assert.svh"
  `CPID_ASSERT_NXT(a_load_leaves_idle, cmd.load, state != StIdle, "accepted word left ctrl idle")
  `CPID_ASSERT_IMP(a_div_count, state == StDiv, cnt <= CntW'(DivW - 1), "divider count overran")
endmodule
`default_nettype wire

// ----- rtl/core/cpid_dp.sv -----
`default_nettype none
module cpid_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cpid_pkg::cmd_t             cmd,
  output cpid_pkg::stat_t                 st,
  input  wire logic [cpid_pkg::InW-1:0]   s_tdata,
  input  wire logic                       s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [cpid_pkg::OutW-1:0]  m_tdata,
  output logic                            m_tuser,
  input  wire logic                       cfg_we,
  input  wire logic [cpid_pkg::AddrW-1:0] cfg_addr,
  input  wire logic [cpid_pkg::LimW-1:0]  cfg_data
);
  import cpid_pkg::*;

  localparam int P1W  = ErrW + DtW + 1;
  localparam int PmW  = ErrW + GainW + 1;
  localparam int ImW  = IntW + GainW + 1;
  localparam int DmW  = MomW + GainW + 1;
  localparam int SumW = DmW + 1;

  logic [GainW-1:0] prop_gain, integ_gain, deriv_gain;
  logic [LimW-1:0]  windup_limit;
  logic [DtW-1:0]   dt_r;
  logic             kind_r;

  logic signed [MomW-1:0] mom_c  [Axes];
  logic                   msat_c [Axes];
  logic                   dsat_r [Axes];

  assign st.in_clear = s_tuser;
  assign st.in_skip  = (s_tdata[InW-1 -: DtW] == '0);
  assign st.out_full = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      windup_limit <= LimitReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegProp:  prop_gain    <= cfg_data[GainW-1:0];
        RegInteg: integ_gain   <= cfg_data[GainW-1:0];
        RegDeriv: deriv_gain   <= cfg_data[GainW-1:0];
        RegLimit: windup_limit <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r   <= s_tdata[InW-1 -: DtW];
      kind_r <= s_tuser;
    end
  end

  for (genvar a = 0; a < Axes; a++) begin : g_axis
    logic signed [ErrW-1:0] tgt_x, meas_x, rate_x, e0, e1, err_c;
    logic signed [ErrW-1:0] err_r, last_r;
    logic signed [IntW-1:0] integ_r, integ_n_r;
    logic signed [ErrW:0]   diff_c, mag_c;
    logic                   neg_r;
    logic [DivW-1:0]        quo;
    logic signed [P1W-1:0]  p1_r, inc_c, isum_c, lim_c, nlim_c;
    logic signed [PmW-1:0]  pm_r, pm_s;
    logic signed [ImW-1:0]  im_r, im_s;
    logic signed [MomW-1:0] deriv_r;
    logic signed [DmW-1:0]  dm_r, dm_s;
    logic signed [SumW-1:0] total_c;
    logic                   hi_c, lo_c;

    assign tgt_x  = $signed({s_tdata[a*AngW + AngW-1], s_tdata[a*AngW +: AngW]});
    assign meas_x = $signed({s_tdata[(Axes+a)*AngW + AngW-1],
                             s_tdata[(Axes+a)*AngW +: AngW]});
    assign rate_x = $signed({s_tdata[(2*Axes+a)*AngW + RateW-1],
                             s_tdata[(2*Axes+a)*AngW +: RateW]});
    assign e0 = tgt_x - meas_x;

    // one wrap step always suffices for a 17-bit difference
    always_comb begin
      if (e0 > AngPi)       e1 = e0 - AngTwoPi;
      else if (e0 < -AngPi) e1 = e0 + AngTwoPi;
      else                  e1 = e0;
    end
    assign err_c = (e1 >>> 1) - rate_x;

    assign diff_c = {err_r[ErrW-1], err_r} - {last_r[ErrW-1], last_r};
    assign mag_c  = diff_c[ErrW] ? -diff_c : diff_c;

    cpid_div u_div (
      .clk      (clk),
      .start    (cmd.prep),
      .step     (cmd.step),
      .dividend ({mag_c[ErrW-1:0], {DtW{1'b0}}}),
      .divisor  (dt_r),
      .quo      (quo)
    );

    always_ff @(posedge clk) begin
      if (cmd.load) err_r <= err_c;
      if (cmd.prep) neg_r <= diff_c[ErrW];
      if (cmd.fin) begin
        if (!neg_r) begin
          dsat_r[a] <= quo[DivW-1] | quo[MomW-1];
          deriv_r   <= (quo[DivW-1] | quo[MomW-1]) ? $signed({1'b0, {(MomW-1){1'b1}}})
                                                   : $signed(quo[MomW-1:0]);
        end else begin
          dsat_r[a] <= quo[DivW-1] | (quo[MomW-1] & |quo[MomW-2:0]);
          deriv_r   <= (quo[DivW-1] | (quo[MomW-1] & |quo[MomW-2:0]))
                       ? $signed({1'b1, {(MomW-1){1'b0}}})
                       : -$signed(quo[MomW-1:0]);
        end
      end
      if (cmd.mult) dm_r <= $signed({1'b0, deriv_gain}) * deriv_r;
    end

    // integral and P/I products settle while the divider runs
    assign inc_c  = p1_r >>> 11;
    assign isum_c = P1W'(integ_r) + inc_c;
    assign lim_c  = $signed(P1W'(windup_limit));
    assign nlim_c = -lim_c;

    always_ff @(posedge clk) begin
      p1_r <= err_r * $signed({1'b0, dt_r});
      if (isum_c > lim_c)       integ_n_r <= lim_c[IntW-1:0];
      else if (isum_c < nlim_c) integ_n_r <= nlim_c[IntW-1:0];
      else                      integ_n_r <= isum_c[IntW-1:0];
      pm_r <= $signed({1'b0, prop_gain}) * err_r;
      im_r <= $signed({1'b0, integ_gain}) * integ_n_r;
    end

    assign pm_s    = pm_r >>> 3;
    assign im_s    = im_r >>> 8;
    assign dm_s    = dm_r >>> 3;
    assign total_c = SumW'(pm_s) + SumW'(im_s) + SumW'(dm_s);
    assign hi_c    = !total_c[SumW-1] && (|total_c[SumW-2:MomW-1]);
    assign lo_c    = total_c[SumW-1] && !(&total_c[SumW-2:MomW-1]);
    assign msat_c[a] = hi_c | lo_c;
    assign mom_c[a]  = hi_c ? $signed({1'b0, {(MomW-1){1'b1}}}) :
                       lo_c ? $signed({1'b1, {(MomW-1){1'b0}}}) : total_c[MomW-1:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        integ_r <= '0;
        last_r  <= '0;
      end else if (cmd.zero && kind_r) begin
        integ_r <= '0;
        last_r  <= '0;
      end else if (cmd.commit) begin
        integ_r <= integ_n_r;
        last_r  <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit || cmd.zero) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero) begin
      m_tdata <= '0;
      m_tuser <= 1'b0;
    end else if (cmd.commit) begin
      m_tdata <= {mom_c[2], mom_c[1], mom_c[0]};
      m_tuser <= dsat_r[0] | dsat_r[1] | dsat_r[2] | msat_c[0] | msat_c[1] | msat_c[2];
    end
  end

`include "cascaded_attitude_rate_pid_unit_assert.svh"
  `CPID_ASSERT_NXT(a_zero_word, cmd.zero, m_tvalid && m_tdata == '0 && !m_tuser, "zero word not emitted")
  `CPID_ASSERT_NXT(a_commit_word, cmd.commit, m_tvalid, "result word not emitted")
endmodule
`default_nettype wire

// ----- rtl/core/cascaded_attitude_rate_pid_unit.sv -----
`default_nettype none
// channel  dir  tdata / data                         tuser
// s_*      in   [159:0] angles, rates, step_time     kind
// m_*      out  [95:0]  moment_x, moment_y, moment_z saturated
// cfg_*    in   cfg_addr selects register, cfg_data   -
//
// A control word walks through capture, divider load, 33 divider steps (the
// restoring divide by step_time), derivative finish, derivative multiply, and
// sum and commit, which waits while the output register is full. At commit the
// output word is registered and the block returns to idle for the next word.
// Clear words and words with step_time zero skip the divide: after capture they
// emit a zero word, which likewise waits while the output register is full.
// One word is in flight at a time; s_tready is high only when idle.
// The output register holds a finished word while m_tready is low; the next
// word can be accepted meanwhile and waits at commit until the register frees.
// rst is synchronous: gains zero, windup limit 10.0, integrals and previous errors zero.
module cascaded_attitude_rate_pid_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // target_roll, target_pitch, target_yaw, meas_roll, meas_pitch, meas_yaw,
  // rate_p, rate_q, rate_r, step_time (lowest first)
  input  wire logic [cpid_pkg::InW-1:0]   s_tdata,
  input  wire logic                       s_tuser,   // kind
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // moment_x, moment_y, moment_z (lowest first)
  output logic      [cpid_pkg::OutW-1:0]  m_tdata,
  output logic                            m_tuser,   // saturated
  input  wire logic                       cfg_we,
  input  wire logic [cpid_pkg::AddrW-1:0] cfg_addr,
  input  wire logic [cpid_pkg::LimW-1:0]  cfg_data
);
  import cpid_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: walks each word through the datapath steps
  cpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // three axis lanes, config registers and output register
  cpid_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );
endmodule
`default_nettype wire
